/* hdl/annular_radial_average_defines.svh */
// assertion macros for the annular radial average checker
// every macro samples on clk and is disabled while rst_n is low
`ifndef ANNULAR_RADIAL_AVERAGE_DEFINES_SVH
`define ANNULAR_RADIAL_AVERAGE_DEFINES_SVH

// condition must hold on the same edge
`define ARAD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold on the following edge
`define ARAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/arad_pkg.sv */
// shared types, widths and constants of the annular radial average block
// no dependencies; imported by every module of the block but arad_ram
`timescale 1ns / 1ps

package arad_pkg;

    // field and register widths
    localparam int unsigned COORD_W    = 10;
    localparam int unsigned POWER_W    = 32;
    localparam int unsigned AVG_W      = 32;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned BIU_W      = 4;
    localparam int unsigned CC_W       = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // bin store layout: count above sum
    localparam int unsigned SUM_W     = 52;
    localparam int unsigned CNT_W     = 21;
    localparam int unsigned ENTRY_W   = SUM_W + CNT_W;
    localparam int unsigned DIVISOR_W = CNT_W + CC_W;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [AVG_W-1:0] ONE_Q16 = 32'h0001_0000;

    localparam int unsigned MAX_BINS = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT = 2'd1;

    localparam logic [BIU_W-1:0] BIU_RESET = 4'd8;
    localparam logic [CC_W-1:0]  CC_RESET  = 16'd1;

    // annulus bounds on 25 * (4 r^2): 100 q^2 and 144 q^2, q = 3 * 2^i
    localparam logic [31:0] BIN_LO_BASE = 32'd900;
    localparam logic [31:0] BIN_HI_BASE = 32'd1296;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_RD,
        ST_CAP,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_OUT
    } arad_state_t;

    function automatic logic [31:0] bin_lo(input logic [IDX_W-1:0] idx);
        return BIN_LO_BASE << {idx, 1'b0};
    endfunction

    function automatic logic [31:0] bin_hi(input logic [IDX_W-1:0] idx);
        return BIN_HI_BASE << {idx, 1'b0};
    endfunction

endpackage

/* hdl/annular_radial_average.sv */
// pixel path: a word passes the offset stages, lhs_reg and the read-modify-write stage into the
// bin ram; one pixel per cycle while in_stall is low, set by the ram read-modify-write with
// write forwarding. frame end: the input stalls while the pipeline drains and each bin in use
// is read out (ram read, capture, divisor multiply, divider start, divide, output load).
// reset: bins_in_use 8, chunk_count 1, per-bin valid flops cleared so every bin reads
// as zero; all of them clear again after each frame, so the bin ram needs no clearing pass.
`timescale 1ns / 1ps

module annular_radial_average #(
    parameter int unsigned FRAME_WIDTH  = 1024,
    parameter int unsigned FRAME_HEIGHT = 1024,
    parameter int unsigned NUM_BINS     = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [arad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arad_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel words
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [arad_pkg::COORD_W-1:0]    pixel_column,
    input  logic [arad_pkg::COORD_W-1:0]    pixel_row,
    input  logic [arad_pkg::POWER_W-1:0]    power_value,
    input  logic                            frame_end,
    // bin result words
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [arad_pkg::IDX_W-1:0]      bin_index,
    output logic [arad_pkg::AVG_W-1:0]      bin_average,
    output logic                            last_bin
);

    import arad_pkg::*;

    localparam int unsigned LIM = (NUM_BINS < MAX_BINS) ? NUM_BINS : MAX_BINS;
    localparam int unsigned AW  = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int unsigned DQX = 2 * $clog2(FRAME_WIDTH + 1);
    localparam int unsigned DQY = 2 * $clog2(FRAME_HEIGHT + 1);
    localparam int unsigned R4W = ((DQX > DQY) ? DQX : DQY) + 1;
    localparam int unsigned LW  = R4W + 5;
    localparam int unsigned PIPE = 4;

    // configuration registers
    logic [BIU_W-1:0] bins_in_use_reg;
    logic [CC_W-1:0]  chunk_count_reg;
    logic [BIU_W-1:0] nb;
    logic [CC_W-1:0]  cc;

    // pixel pipeline
    logic                 pv_reg [PIPE];
    logic [POWER_W-1:0]   pp_reg [PIPE];
    logic                 pf_reg [PIPE];
    logic [DQX-1:0]       dsq_x;
    logic [DQY-1:0]       dsq_y;
    logic [R4W-1:0]       r4;
    logic [LW-1:0]        lhs_reg;
    logic [31:0]          lhs_cmp;
    logic                 hit;
    logic [AW-1:0]        hit_idx;

    // bin store access
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [LIM-1:0]       vbit_reg;
    logic [LIM-1:0]       vbit_next;
    logic                 rd_vbit_reg;

    // read-modify-write stage
    logic                 s5_valid_reg;
    logic                 s5_hit_reg;
    logic [AW-1:0]        s5_idx_reg;
    logic [POWER_W-1:0]   s5_pwr_reg;
    logic                 s5_fend_reg;
    logic                 fwd_en_reg;
    logic [AW-1:0]        fwd_addr_reg;
    logic [ENTRY_W-1:0]   fwd_data_reg;
    logic [ENTRY_W-1:0]   old_entry;
    logic [SUM_W-1:0]     old_sum;
    logic [CNT_W-1:0]     old_cnt;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-1:0]     new_sum;
    logic [CNT_W-1:0]     new_cnt;

    // emission
    arad_state_t          state_reg;
    arad_state_t          state_next;
    logic [IDX_W-1:0]     bin_cnt_reg;
    logic [IDX_W-1:0]     bin_cnt_next;
    logic                 cap_en;
    logic                 mul_en;
    logic                 div_start;
    logic                 div_done;
    logic                 load_out;
    logic                 em_last;
    logic [SUM_W-1:0]     cap_sum_reg;
    logic [CNT_W-1:0]     cap_cnt_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [SUM_W-1:0]     quotient;
    logic [AVG_W-1:0]     avg;

    // output register
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     bin_index_reg;
    logic [AVG_W-1:0]     bin_average_reg;
    logic                 last_bin_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= BIU_RESET;
            chunk_count_reg <= CC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BIU_W-1:0];
                REG_CHUNK_COUNT: chunk_count_reg <= cfg_data[CC_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamp bins in use, zero chunk count acts as one
    always_comb
    begin
        if (bins_in_use_reg == '0)
        begin
            nb = BIU_W'(1);
        end
        else if (bins_in_use_reg > BIU_W'(LIM))
        begin
            nb = BIU_W'(LIM);
        end
        else
        begin
            nb = bins_in_use_reg;
        end
    end

    assign cc = (chunk_count_reg == '0) ? CC_W'(1) : chunk_count_reg;

    // squared offsets of both coordinates
    arad_offset #(
        .SIZE (FRAME_WIDTH)
    ) u_offset_x (
        .clk   (clk),
        .coord (pixel_column),
        .dsq   (dsq_x)
    );

    arad_offset #(
        .SIZE (FRAME_HEIGHT)
    ) u_offset_y (
        .clk   (clk),
        .coord (pixel_row),
        .dsq   (dsq_y)
    );

    // word valid and side data alongside the offset stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            pv_reg[0] <= in_valid && !in_stall;
            for (int i = 1; i < PIPE; i++)
            begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg[0] <= power_value;
        pf_reg[0] <= frame_end;
        for (int i = 1; i < PIPE; i++)
        begin
            pp_reg[i] <= pp_reg[i-1];
            pf_reg[i] <= pf_reg[i-1];
        end
    end

    // 25 * 4 r^2
    assign r4 = R4W'(dsq_x) + R4W'(dsq_y);

    always_ff @(posedge clk)
    begin
        lhs_reg <= LW'(LW'(r4) * LW'(25));
    end

    // annulus test, bins never overlap so at most one hits
    assign lhs_cmp = 32'(lhs_reg);

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < LIM; i++)
        begin
            if ((BIU_W'(i) < nb) && (lhs_cmp >= bin_lo(IDX_W'(i)))
                && (lhs_cmp <= bin_hi(IDX_W'(i))))
            begin
                hit     = 1'b1;
                hit_idx = AW'(i);
            end
        end
    end

    // bin store: {count, sum} per bin
    assign ram_raddr = (state_reg == ST_RD) ? bin_cnt_reg[AW-1:0] : hit_idx;

    arad_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIM)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s5_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read-modify-write stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            fwd_en_reg   <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= pv_reg[PIPE-1];
            fwd_en_reg   <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_hit_reg   <= hit;
        s5_idx_reg   <= hit_idx;
        s5_pwr_reg   <= pp_reg[PIPE-1];
        s5_fend_reg  <= pf_reg[PIPE-1];
        rd_vbit_reg  <= vbit_reg[ram_raddr];
        fwd_addr_reg <= s5_idx_reg;
        fwd_data_reg <= ram_wdata;
    end

    // forward the previous cycle's write, unwritten bins read as zero
    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == s5_idx_reg))
        begin
            old_entry = fwd_data_reg;
        end
        else if (rd_vbit_reg)
        begin
            old_entry = ram_rdata;
        end
        else
        begin
            old_entry = '0;
        end
    end

    assign old_sum  = old_entry[SUM_W-1:0];
    assign old_cnt  = old_entry[ENTRY_W-1:SUM_W];
    assign sum_wide = {1'b0, old_sum} + (SUM_W + 1)'(s5_pwr_reg);
    assign new_sum  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign new_cnt  = (old_cnt == CNT_MAX) ? CNT_MAX : (old_cnt + 1'b1);

    assign ram_we    = s5_valid_reg && s5_hit_reg;
    assign ram_wdata = {new_cnt, new_sum};

    // per-bin valid flops: set on accumulate, cleared when emitted, all cleared at frame close
    always_comb
    begin
        vbit_next = vbit_reg;
        if (ram_we)
        begin
            vbit_next[s5_idx_reg] = 1'b1;
        end
        if (cap_en)
        begin
            vbit_next[bin_cnt_reg[AW-1:0]] = 1'b0;
        end
        if (load_out && em_last)
        begin
            vbit_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbit_reg <= '0;
        end
        else
        begin
            vbit_reg <= vbit_next;
        end
    end

    // emission sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            bin_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bin_cnt_reg <= bin_cnt_next;
        end
    end

    assign em_last  = ((BIU_W'(bin_cnt_reg) + BIU_W'(1)) == nb);
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // next state and strobes
    always_comb
    begin
        state_next   = state_reg;
        bin_cnt_next = bin_cnt_reg;
        in_stall     = 1'b1;
        cap_en       = 1'b0;
        mul_en       = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_stall     = 1'b0;
                bin_cnt_next = '0;
                if (in_valid && frame_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s5_valid_reg && s5_fend_reg)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                cap_en     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    if (em_last)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        bin_cnt_next = bin_cnt_reg + 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // capture the bin and form count * chunks
    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            cap_sum_reg <= rd_vbit_reg ? ram_rdata[SUM_W-1:0] : '0;
            cap_cnt_reg <= rd_vbit_reg ? ram_rdata[ENTRY_W-1:SUM_W] : '0;
        end
        if (mul_en)
        begin
            divisor_reg <= DIVISOR_W'(cap_cnt_reg) * DIVISOR_W'(cc);
        end
    end

    arad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cap_sum_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // empty bin gives one, otherwise saturate to 32 bits
    always_comb
    begin
        if (cap_cnt_reg == '0)
        begin
            avg = ONE_Q16;
        end
        else if (quotient[SUM_W-1:AVG_W] != '0)
        begin
            avg = '1;
        end
        else
        begin
            avg = quotient[AVG_W-1:0];
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            bin_index_reg   <= bin_cnt_reg;
            bin_average_reg <= avg;
            last_bin_reg    <= em_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_index   = bin_index_reg;
    assign bin_average = bin_average_reg;
    assign last_bin    = last_bin_reg;

endmodule

/* hdl/arad_ram.sv */
// generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module arad_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/arad_offset.sv */
// shifted doubled offset squared of one coordinate, three register stages
// depends on arad_pkg for the coordinate width
`timescale 1ns / 1ps

module arad_offset #(
    parameter int unsigned SIZE = 1024
) (
    input  logic                                clk,
    input  logic [arad_pkg::COORD_W-1:0]        coord,
    output logic [2*$clog2(SIZE + 1)-1:0]       dsq
);

    import arad_pkg::*;

    // shifted coordinate before the modulo
    localparam int unsigned VW = $clog2((1 << COORD_W) + SIZE / 2);
    // reciprocal of SIZE, exact floor for every value below 2^12
    localparam int unsigned RECIP_SHIFT = 24;
    localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + SIZE - 1) / SIZE;
    localparam int unsigned RW = $clog2(RECIP + 1);
    localparam int unsigned PW = VW + RW;
    localparam int unsigned QW = PW - RECIP_SHIFT;
    localparam int unsigned CW = VW + 2;
    localparam int unsigned DW = $clog2(SIZE + 1);
    localparam int unsigned SQW = 2 * DW;

    logic [VW-1:0]  v;
    logic [PW-1:0]  prod_reg;
    logic [VW-1:0]  v_reg;
    logic [QW-1:0]  quo;
    logic [VW-1:0]  quo_size;
    logic [VW-1:0]  shifted;
    logic [CW-1:0]  twice;
    logic [CW-1:0]  size_c;
    logic [CW-1:0]  diff;
    logic [DW-1:0]  d_reg;
    logic [SQW-1:0] dsq_reg;

    // stage a: add half the size and multiply by the reciprocal
    assign v = VW'(coord) + VW'(SIZE / 2);

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(v) * PW'(RECIP);
        v_reg    <= v;
    end

    // stage b: remainder and distance of 2s from the size
    assign quo      = prod_reg[PW-1:RECIP_SHIFT];
    assign quo_size = VW'(VW'(quo) * VW'(SIZE));
    assign shifted  = v_reg - quo_size;
    assign twice    = CW'({shifted, 1'b0});
    assign size_c   = CW'(SIZE);
    assign diff     = (twice >= size_c) ? (twice - size_c) : (size_c - twice);

    always_ff @(posedge clk)
    begin
        d_reg <= DW'(diff);
    end

    // stage c: square
    always_ff @(posedge clk)
    begin
        dsq_reg <= SQW'(d_reg) * SQW'(d_reg);
    end

    assign dsq = dsq_reg;

endmodule

/* hdl/arad_div.sv */
// restoring divider, one quotient bit per cycle, for the bin averages
// depends on arad_pkg for the sum and divisor widths
`timescale 1ns / 1ps

module arad_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [arad_pkg::SUM_W-1:0]     dividend,
    input  logic [arad_pkg::DIVISOR_W-1:0] divisor,
    output logic                           done,
    output logic [arad_pkg::SUM_W-1:0]     quotient
);

    import arad_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // one trial subtraction
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign trial     = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/arad_checker.sv */
// port-level checks of the annular radial average block, bound to the top level
// depends on arad_pkg and annular_radial_average_defines.svh
`timescale 1ns / 1ps
`include "annular_radial_average_defines.svh"

module arad_checker #(
    parameter int unsigned NUM_BINS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       frame_end,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [arad_pkg::IDX_W-1:0] bin_index,
    input  logic [arad_pkg::AVG_W-1:0] bin_average,
    input  logic                       last_bin
);

    import arad_pkg::*;

    localparam int unsigned LIM = (NUM_BINS < MAX_BINS) ? NUM_BINS : MAX_BINS;

    // a stalled result word holds
    `ARAD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bin_index) && $stable(bin_average) && $stable(last_bin), "stalled result word changed")

    // only bins inside the store are reported
    `ARAD_ASSERT_SAME(a_bin_range, out_valid, 32'(bin_index) < LIM, "bin index beyond bins in store")

    // no pixel is taken right after a taken frame end word
    `ARAD_ASSERT_NEXT(a_fend_stall, in_valid && !in_stall && frame_end, in_stall, "pixel taken right after frame end")

    // while a result word other than the last is on the output, no pixel is taken
    `ARAD_ASSERT_SAME(a_emit_stall, out_valid && !last_bin, in_stall, "pixel taken in the middle of emission")

endmodule

bind annular_radial_average arad_checker #(
    .NUM_BINS (NUM_BINS)
) u_arad_checker (.*);

/* bench/annular_radial_average_tb.sv */
// testbench for annular_radial_average: directed pixel table, then random frames
// checked word by word against an in-bench bin accumulator; depends on arad_pkg
`timescale 1ns / 1ps

module annular_radial_average_tb;

    import arad_pkg::*;

    localparam int unsigned FRAME_W      = 1024;
    localparam int unsigned FRAME_H      = 1024;
    localparam int unsigned RINGS        = 8;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_PIXELS = 21;
    localparam int unsigned DIR_ROWS     = 19;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef logic [0:MAX_BINS-1][AVG_W-1:0] ring_avgs_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [AVG_W-1:0] avg;
        logic             last;
    } bin_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [POWER_W-1:0] power;
        logic               closes_frame;
        logic               known;
        ring_avgs_t         avgs;
    } pixel_row_t;

    localparam ring_avgs_t NO_AVGS    = '0;
    localparam ring_avgs_t EMPTY_AVGS = {MAX_BINS{ONE_Q16}};

    // directed pixels; frames with known bin averages carry them
    pixel_row_t directed_rows [DIR_ROWS] = '{
        // right after reset, pixel at the centre: every bin empty
        '{10'd0,    10'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, EMPTY_AVGS},
        // one pixel on the inner edge of each bin, last one closes the frame
        '{10'd3,    10'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_AVGS},
        '{10'd0,    10'd6,   32'h0000_0000, 1'b0, 1'b0, NO_AVGS},
        '{10'd1012, 10'd0,   32'h0001_0000, 1'b0, 1'b0, NO_AVGS},
        '{10'd0,    10'd1000, 32'h1234_5678, 1'b0, 1'b0, NO_AVGS},
        '{10'd48,   10'd0,   32'h0000_0001, 1'b0, 1'b0, NO_AVGS},
        '{10'd0,    10'd96,  32'hAAAA_AAAA, 1'b0, 1'b0, NO_AVGS},
        '{10'd832,  10'd0,   32'h5555_5555, 1'b0, 1'b0, NO_AVGS},
        '{10'd0,    10'd640, 32'h8000_0000, 1'b1, 1'b1,
          {32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h1234_5678,
           32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000}},
        // bin edges, wrapped coordinates, far corner
        '{10'd3,    10'd1,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_AVGS},
        '{10'd1021, 10'd1023, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_AVGS},
        '{10'd3,    10'd2,   32'h0BAD_0000, 1'b0, 1'b0, NO_AVGS},
        '{10'd2,    10'd2,   32'h7FFF_FFFF, 1'b0, 1'b0, NO_AVGS},
        '{10'd7,    10'd1,   32'h0000_0003, 1'b0, 1'b0, NO_AVGS},
        '{10'd6,    10'd4,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_AVGS},
        '{10'd1018, 10'd0,   32'h0000_0004, 1'b0, 1'b0, NO_AVGS},
        '{10'd460,  10'd0,   32'h0000_000A, 1'b0, 1'b0, NO_AVGS},
        '{10'd461,  10'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_AVGS},
        '{10'd512,  10'd512, 32'hFFFF_FFFF, 1'b1, 1'b1,
          {32'hFFFF_FFFF, 32'h0000_0003, 32'h0001_0000, 32'h0001_0000,
           32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_000A}}
    };

    // per-phase register settings and idling
    logic [CFG_DATA_W-1:0] plan_bins [PHASES] = '{
        16'd8, 16'd1, 16'd15, 16'd0, 16'hABC3, 16'd8, 16'd6, 16'd4
    };
    logic [CFG_DATA_W-1:0] plan_chunks [PHASES] = '{
        16'd1, 16'd65535, 16'd0, 16'd7, 16'd1, 16'd65535, 16'd0, 16'd250
    };
    idle_mode_t plan_idle [PHASES] = '{
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [COORD_W-1:0]    pixel_column;
    logic [COORD_W-1:0]    pixel_row;
    logic [POWER_W-1:0]    power_value;
    logic                  frame_end;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [IDX_W-1:0]      bin_index;
    logic [AVG_W-1:0]      bin_average;
    logic                  last_bin;

    // known averages travel alongside the pixel word
    logic       known_frame;
    ring_avgs_t known_avgs;

    idle_mode_t  idle_mode;
    logic        pressure_armed;
    logic        pressure_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycles_run = 0;
    int unsigned failures = 0;

    // bin accumulator state
    logic [SUM_W-1:0] ring_sum   [MAX_BINS];
    logic [CNT_W-1:0] ring_count [MAX_BINS];
    logic [BIU_W-1:0] bins_reg;
    logic [CC_W-1:0]  chunks_reg;
    bin_word_t        expected_bins [$];

    annular_radial_average #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H),
        .NUM_BINS     (RINGS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .power_value  (power_value),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bin_index    (bin_index),
        .bin_average  (bin_average),
        .last_bin     (last_bin)
    );

    always #1 clk = ~clk;

    // doubled offset from the frame centre after the fft shift, squared
    function automatic longint unsigned offset_sq(input logic [COORD_W-1:0] coord,
                                                  input longint unsigned size);
        longint unsigned shifted;
        longint unsigned twice;
        longint unsigned delta;
        shifted = (64'(coord) + size / 2) % size;
        twice = 2 * shifted;
        delta = (twice >= size) ? twice - size : size - twice;
        return delta * delta;
    endfunction

    function automatic int unsigned active_rings();
        int unsigned lim;
        int unsigned n;
        lim = (RINGS < MAX_BINS) ? RINGS : MAX_BINS;
        n = bins_reg;
        if (n < 1) n = 1;
        if (n > lim) n = lim;
        return n;
    endfunction

    // add one pixel to its annuli; on frame end queue one word per active bin
    function automatic void record_pixel(input logic [COORD_W-1:0] col,
                                         input logic [COORD_W-1:0] row,
                                         input logic [POWER_W-1:0] power,
                                         input logic closes_frame);
        longint unsigned r4;
        longint unsigned lhs;
        longint unsigned q;
        longint unsigned sum;
        longint unsigned divisor;
        longint unsigned avg;
        int unsigned nb;
        bin_word_t w;
        nb = active_rings();
        r4 = offset_sq(col, FRAME_W) + offset_sq(row, FRAME_H);
        lhs = 25 * r4;
        for (int i = 0; i < nb; i++)
        begin
            q = 64'd3 << i;
            if (lhs >= 100 * q * q && lhs <= 144 * q * q)
            begin
                sum = 64'(ring_sum[i]) + 64'(power);
                ring_sum[i] = (sum > 64'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
                if (ring_count[i] != CNT_MAX)
                    ring_count[i] = ring_count[i] + 1'b1;
            end
        end
        if (closes_frame)
        begin
            for (int i = 0; i < nb; i++)
            begin
                if (ring_count[i] == '0)
                    avg = 64'(ONE_Q16);
                else
                begin
                    divisor = 64'(ring_count[i]) * ((chunks_reg == '0) ? 64'd1 : 64'(chunks_reg));
                    avg = 64'(ring_sum[i]) / divisor;
                    if (avg > 64'hFFFF_FFFF)
                        avg = 64'hFFFF_FFFF;
                end
                w.idx = IDX_W'(i);
                w.avg = avg[AVG_W-1:0];
                w.last = (i == nb - 1);
                expected_bins.push_back(w);
            end
            for (int i = 0; i < MAX_BINS; i++)
            begin
                ring_sum[i] = '0;
                ring_count[i] = '0;
            end
        end
    endfunction

    // track config, predict on accepted pixels, check accepted bin words
    always @(posedge clk)
    begin : scoreboard
        int unsigned queued;
        bin_word_t w;
        if (!rst_n)
        begin
            bins_reg = BIU_RESET;
            chunks_reg = CC_RESET;
            for (int i = 0; i < MAX_BINS; i++)
            begin
                ring_sum[i] = '0;
                ring_count[i] = '0;
            end
            expected_bins.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BINS_IN_USE)
                    bins_reg = cfg_data[BIU_W-1:0];
                else if (cfg_index == REG_CHUNK_COUNT)
                    chunks_reg = cfg_data[CC_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                queued = expected_bins.size();
                record_pixel(pixel_column, pixel_row, power_value, frame_end);
                // known frames replace the predicted words by the typed ones
                if (known_frame && frame_end)
                begin
                    while (expected_bins.size() > queued)
                        void'(expected_bins.pop_back());
                    for (int k = 0; k < MAX_BINS; k++)
                    begin
                        w.idx = IDX_W'(k);
                        w.avg = known_avgs[k];
                        w.last = (k == MAX_BINS - 1);
                        expected_bins.push_back(w);
                    end
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_bins.size() == 0)
                begin
                    $error("bin word with none expected: bin_index %0d bin_average %h",
                           bin_index, bin_average);
                    failures++;
                end
                else
                begin
                    w = expected_bins.pop_front();
                    if (bin_index !== w.idx)
                    begin
                        $error("bin_index: expected %0d, got %0d", w.idx, bin_index);
                        failures++;
                    end
                    if (bin_average !== w.avg)
                    begin
                        $error("bin_average: expected %h, got %h", w.avg, bin_average);
                        failures++;
                    end
                    if (last_bin !== w.last)
                    begin
                        $error("last_bin: expected %0b, got %0b", w.last, last_bin);
                        failures++;
                    end
                end
            end
        end
    end

    // output side: random stall by phase, one long hold-off when armed
    always @(posedge clk)
    begin : receiver
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (pressure_armed && !pressure_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
        else if (idle_mode == IDLE_RECEIVER)
            out_stall <= ($urandom_range(0, 99) < 79);
        else if (idle_mode == IDLE_BOTH)
            out_stall <= ($urandom_range(0, 99) < 25);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one pixel word and hold it until taken
    task automatic offer_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                               input logic [POWER_W-1:0] power, input logic closes_frame,
                               input logic known, input ring_avgs_t avgs);
        int unsigned gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 79 : (idle_mode == IDLE_BOTH) ? 25 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_column <= col;
        pixel_row <= row;
        power_value <= power;
        frame_end <= closes_frame;
        known_frame <= known;
        known_avgs <= avgs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, wait out all bin words and the pipeline tail
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random point inside annulus ring, inner edge if none found
    task automatic pick_ring_pixel(input int unsigned ring, output logic [COORD_W-1:0] col,
                                   output logic [COORD_W-1:0] row);
        longint q2;
        longint r2;
        int span;
        int ex;
        int ey;
        int cx;
        int cy;
        bit found;
        q2 = 64'd9 << (2 * ring);
        span = (36 << ring) / 10 + 1;
        if (span > 511)
            span = 511;
        ex = 3 << ring;
        ey = 0;
        found = 1'b0;
        for (int t = 0; t < 64 && !found; t++)
        begin
            cx = int'($urandom_range(0, 2 * span)) - span;
            cy = int'($urandom_range(0, 2 * span)) - span;
            r2 = longint'(cx) * cx + longint'(cy) * cy;
            if (r2 >= q2 && 100 * r2 <= 144 * q2)
            begin
                ex = cx;
                ey = cy;
                found = 1'b1;
            end
        end
        col = COORD_W'(ex);
        row = COORD_W'(ey);
    endtask

    function automatic logic [POWER_W-1:0] pick_power();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return POWER_W'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    // mostly annulus pixels, some noise anywhere in the frame
    task automatic send_random_frame(input int unsigned pixels);
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        for (int unsigned k = 0; k < pixels; k++)
        begin
            if ($urandom_range(0, 4) != 0)
                pick_ring_pixel($urandom_range(0, MAX_BINS - 1), col, row);
            else
            begin
                col = COORD_W'($urandom);
                row = COORD_W'($urandom);
            end
            offer_pixel(col, row, pick_power(), k == pixels - 1, 1'b0, NO_AVGS);
        end
    endtask

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BINS_IN_USE;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_column = '0;
        pixel_row = '0;
        power_value = '0;
        frame_end = 1'b0;
        known_frame = 1'b0;
        known_avgs = NO_AVGS;
        idle_mode = IDLE_NONE;
        pressure_armed = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings
        for (int k = 0; k < DIR_ROWS; k++)
            offer_pixel(directed_rows[k].col, directed_rows[k].row, directed_rows[k].power,
                        directed_rows[k].closes_frame, directed_rows[k].known,
                        directed_rows[k].avgs);
        settle_block();

        // random frames, one register setting and idling pattern per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_mode <= plan_idle[ph];
            write_register(REG_BINS_IN_USE, plan_bins[ph]);
            write_register(REG_CHUNK_COUNT, plan_chunks[ph]);
            if (ph == 4)
                pressure_armed <= 1'b1;
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                len = $urandom_range(1, 10);
                send_random_frame(len);
                sent += len;
            end
            settle_block();
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
